// ===== rtl/core/efa_pkg.sv =====
`default_nettype none

package efa_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 256;
  localparam int COUNT_BITS = 16;

  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int PIX_BITS   = COL_BITS + ROW_BITS;
  localparam int ADDR_BITS  = PIX_BITS + 1;
  localparam int RAM_DEPTH  = 1 << ADDR_BITS;
  localparam int WORD_BITS  = 2 * COUNT_BITS;
  localparam int SUM_BITS   = COUNT_BITS + 1;
  localparam int SCALE_BITS = SUM_BITS + 8;

  localparam int DIM_BITS       = 9;
  localparam int LEN_BITS       = 32;
  localparam int TS_BITS        = 64;
  localparam int CFG_BITS       = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int LEVEL_BITS     = 8;

  localparam int DIV_STEPS    = TS_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd2;

  localparam logic [DIM_BITS-1:0] FRAME_DIM_RST     = 9'd256;
  localparam logic [LEN_BITS-1:0] WINDOW_LENGTH_RST = 32'd33000000;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam int SCALE_FULL = 255;
  localparam int SCALE_MID  = 127;
  localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MID  = 8'd127;

  typedef struct packed {
    logic                func;
    logic [15:0]         x;
    logic [15:0]         y;
    logic                polarity;
    logic [TS_BITS-1:0]  timestamp;
  } in_t;

  typedef struct packed {
    logic                  window_closed;
    logic [TS_BITS-1:0]    frame_stamp;
    logic                  read_valid;
    logic [LEVEL_BITS-1:0] count_gray;
    logic [LEVEL_BITS-1:0] signed_gray;
    logic [LEVEL_BITS-1:0] binary_level;
    logic [LEVEL_BITS-1:0] red_level;
    logic [LEVEL_BITS-1:0] blue_level;
  } out_t;

  typedef enum logic [1:0] {
    OP_TOTAL,
    OP_POS,
    OP_NEG,
    OP_SIGNED
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_KIND,
    S_CHECK,
    S_SCAN,
    S_SCAN_TAIL,
    S_COMMIT,
    S_CNT_RD,
    S_CNT_WR,
    S_PIX_RD,
    S_PIX_LATCH,
    S_DIV_GO,
    S_DIV_RUN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic set_start;
    logic sweep_clear;
    logic sweep_reset;
    logic scan_step;
    logic div_time;
    logic div_read;
    logic close_commit;
    logic cnt_read;
    logic cnt_write;
    logic pix_read;
    logic pix_latch;
    logic level_store;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic close_hit;
    logic sweep_last_pix;
    logic sweep_last_all;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/efa_ram.sv =====
`default_nettype none

module efa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/efa_div.sv =====
`default_nettype none

module efa_div
  import efa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [TS_BITS-1:0]  dividend,
  input  wire logic [LEN_BITS-1:0] divisor,
  output logic                     busy,
  output logic      [TS_BITS-1:0]  quotient,
  output logic      [LEN_BITS-1:0] remainder
);

  logic [LEN_BITS-1:0]     dsr;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [LEN_BITS:0]       trial;
  logic [LEN_BITS:0]       diff;
  logic                    ge;

  // restoring division, one quotient bit a cycle
  assign trial = {remainder, quotient[TS_BITS-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[TS_BITS-2:0], ge};
      remainder <= ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/efa_ctrl.sv =====
`default_nettype none

module efa_ctrl
  import efa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;
  op_t    op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      op    <= OP_TOTAL;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      S_CLEAR: begin
        if (status.sweep_last_all) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_KIND;
      end
      S_KIND: begin
        state_next = status.is_read ? S_PIX_RD : S_CHECK;
      end
      S_CHECK: begin
        state_next = status.close_hit ? S_SCAN : S_CNT_RD;
      end
      S_SCAN: begin
        if (status.sweep_last_pix) state_next = S_SCAN_TAIL;
      end
      S_SCAN_TAIL: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!status.div_busy) state_next = S_CNT_RD;
      end
      S_CNT_RD: begin
        state_next = S_CNT_WR;
      end
      S_CNT_WR: begin
        state_next = S_OUT;
      end
      S_PIX_RD: begin
        state_next = S_PIX_LATCH;
      end
      S_PIX_LATCH: begin
        op_next    = OP_TOTAL;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_next = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (!status.div_busy) begin
          if (op == OP_SIGNED) begin
            state_next = S_OUT;
          end else begin
            op_next    = op_t'(op + 2'd1);
            state_next = S_DIV_GO;
          end
        end
      end
      S_OUT: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.op   = op;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_CLEAR:     cmd.sweep_clear = 1'b1;
      S_IDLE:      cmd.capture     = in_valid;
      S_KIND:      cmd.set_start   = !status.is_read;
      S_CHECK: begin
        cmd.sweep_reset = status.close_hit;
        cmd.div_time    = status.close_hit;
      end
      S_SCAN:      cmd.scan_step    = 1'b1;
      S_SCAN_TAIL: cmd.scan_step    = 1'b0;
      S_COMMIT:    cmd.close_commit = !status.div_busy;
      S_CNT_RD:    cmd.cnt_read     = 1'b1;
      S_CNT_WR:    cmd.cnt_write    = 1'b1;
      S_PIX_RD:    cmd.pix_read     = 1'b1;
      S_PIX_LATCH: cmd.pix_latch    = 1'b1;
      S_DIV_GO:    cmd.div_read     = 1'b1;
      S_DIV_RUN:   cmd.level_store  = !status.div_busy;
      S_OUT:       cmd.out_load     = status.out_free;
      default:     cmd              = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/efa_dp.sv =====
`default_nettype none

module efa_dp
  import efa_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data,
  input  wire cmd_t                      cmd,
  output status_t                        status,
  input  wire in_t                       item_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_t                           out_item
);

  logic [DIM_BITS-1:0]   frame_width;
  logic [DIM_BITS-1:0]   frame_height;
  logic [LEN_BITS-1:0]   window_length;

  in_t                   item;
  logic                  started;
  logic                  present;
  logic                  bank;
  logic                  closed_flag;
  logic [TS_BITS-1:0]    window_start;
  logic [TS_BITS-1:0]    closed_stamp;
  logic [ADDR_BITS-1:0]  sweep;

  logic                  scan_pend;
  logic                  scan_inside;
  logic [SUM_BITS-1:0]   acc_total;
  logic [COUNT_BITS-1:0] acc_pos;
  logic [COUNT_BITS-1:0] acc_neg;
  logic [COUNT_BITS-1:0] acc_abs;
  logic [SUM_BITS-1:0]   max_total;
  logic [COUNT_BITS-1:0] max_pos;
  logic [COUNT_BITS-1:0] max_neg;
  logic [COUNT_BITS-1:0] max_abs;

  logic [COUNT_BITS-1:0] pix_pos;
  logic [COUNT_BITS-1:0] pix_neg;
  logic [LEVEL_BITS-1:0] lvl_count;
  logic [LEVEL_BITS-1:0] lvl_signed;
  logic [LEVEL_BITS-1:0] lvl_red;
  logic [LEVEL_BITS-1:0] lvl_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_DIM_RST;
      frame_height  <= FRAME_DIM_RST;
      window_length <= WINDOW_LENGTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:   frame_width   <= cfg_data[DIM_BITS-1:0];
        CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[DIM_BITS-1:0];
        CFG_WINDOW_LENGTH: window_length <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // window timing
  logic [LEN_BITS-1:0] len_eff;
  logic [TS_BITS-1:0]  ts_diff;
  logic                item_inside;

  assign len_eff  = (window_length == '0) ? LEN_BITS'(1) : window_length;
  assign ts_diff  = item.timestamp - window_start;
  assign item_inside = (item.x < 16'(frame_width))  && (item.x < 16'(MAX_COLS)) &&
                       (item.y < 16'(frame_height)) && (item.y < 16'(MAX_ROWS));

  // memory: {bank, row, column} -> {positive, negative}
  logic [PIX_BITS-1:0]  item_pix;
  logic [ADDR_BITS-1:0] raddr;
  logic [ADDR_BITS-1:0] waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rdata;
  logic                 we;
  logic [COUNT_BITS-1:0] rd_pos;
  logic [COUNT_BITS-1:0] rd_neg;
  logic [COUNT_BITS-1:0] inc_pos;
  logic [COUNT_BITS-1:0] inc_neg;
  logic [COL_BITS-1:0]  scan_col;
  logic [ROW_BITS-1:0]  scan_row;

  assign item_pix = {item.y[ROW_BITS-1:0], item.x[COL_BITS-1:0]};
  assign rd_pos   = rdata[WORD_BITS-1:COUNT_BITS];
  assign rd_neg   = rdata[COUNT_BITS-1:0];
  assign scan_col = sweep[COL_BITS-1:0];
  assign scan_row = sweep[PIX_BITS-1:COL_BITS];

  always_comb begin
    inc_pos = rd_pos;
    inc_neg = rd_neg;
    if (item.polarity) begin
      if (rd_pos != COUNT_MAX) inc_pos = rd_pos + 1'b1;
    end else begin
      if (rd_neg != COUNT_MAX) inc_neg = rd_neg + 1'b1;
    end
  end

  always_comb begin
    if (cmd.scan_step) begin
      raddr = {bank, sweep[PIX_BITS-1:0]};
    end else if (cmd.cnt_read) begin
      raddr = {bank, item_pix};
    end else begin
      raddr = {~bank, item_pix};
    end
    we    = cmd.sweep_clear | cmd.scan_step | (cmd.cnt_write & item_inside);
    wdata = '0;
    if (cmd.sweep_clear) begin
      waddr = sweep;
    end else if (cmd.scan_step) begin
      waddr = {~bank, sweep[PIX_BITS-1:0]};
    end else begin
      waddr = {bank, item_pix};
      wdata = {inc_pos, inc_neg};
    end
  end

  efa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // scan accumulation
  logic [SUM_BITS-1:0]   rd_total;
  logic [COUNT_BITS-1:0] rd_abs;

  assign rd_total = SUM_BITS'(rd_pos) + SUM_BITS'(rd_neg);
  assign rd_abs   = (rd_pos >= rd_neg) ? rd_pos - rd_neg : rd_neg - rd_pos;

  // divider operands
  logic [SUM_BITS-1:0]   pix_total;
  logic                  pix_ge;
  logic [COUNT_BITS-1:0] pix_abs;
  logic [SCALE_BITS-1:0] total_sc;
  logic [SCALE_BITS-1:0] pos_sc;
  logic [SCALE_BITS-1:0] neg_sc;
  logic [SCALE_BITS-1:0] mabs_sc;
  logic [SCALE_BITS-1:0] dabs_sc;
  logic [TS_BITS-1:0]    rd_dividend;
  logic [LEN_BITS-1:0]   rd_divisor;
  logic                  rd_max_zero;
  logic                  div_start;
  logic [TS_BITS-1:0]    div_dividend;
  logic [LEN_BITS-1:0]   div_divisor;
  logic                  div_busy;
  logic [TS_BITS-1:0]    div_quo;
  logic [LEN_BITS-1:0]   div_rem;

  assign pix_total = SUM_BITS'(pix_pos) + SUM_BITS'(pix_neg);
  assign pix_ge    = pix_pos >= pix_neg;
  assign pix_abs   = pix_ge ? pix_pos - pix_neg : pix_neg - pix_pos;
  assign total_sc  = SCALE_BITS'(pix_total) * SCALE_BITS'(SCALE_FULL);
  assign pos_sc    = SCALE_BITS'(pix_pos) * SCALE_BITS'(SCALE_FULL);
  assign neg_sc    = SCALE_BITS'(pix_neg) * SCALE_BITS'(SCALE_FULL);
  assign mabs_sc   = SCALE_BITS'(max_abs) * SCALE_BITS'(SCALE_MID);
  assign dabs_sc   = SCALE_BITS'(pix_abs) * SCALE_BITS'(SCALE_MID);

  always_comb begin
    case (cmd.op)
      OP_TOTAL: begin
        rd_dividend = TS_BITS'(total_sc);
        rd_max_zero = (max_total == '0);
        rd_divisor  = LEN_BITS'(max_total);
      end
      OP_POS: begin
        rd_dividend = TS_BITS'(pos_sc);
        rd_max_zero = (max_pos == '0);
        rd_divisor  = LEN_BITS'(max_pos);
      end
      OP_NEG: begin
        rd_dividend = TS_BITS'(neg_sc);
        rd_max_zero = (max_neg == '0);
        rd_divisor  = LEN_BITS'(max_neg);
      end
      default: begin
        // wraps when the pixel lies outside the scanned frame
        rd_dividend = pix_ge ? TS_BITS'(mabs_sc) + TS_BITS'(dabs_sc)
                             : TS_BITS'(mabs_sc) - TS_BITS'(dabs_sc);
        rd_max_zero = (max_abs == '0);
        rd_divisor  = LEN_BITS'(max_abs);
      end
    endcase
    if (rd_max_zero) rd_divisor = LEN_BITS'(1);
  end

  assign div_start    = cmd.div_time | cmd.div_read;
  assign div_dividend = cmd.div_time ? ts_diff : rd_dividend;
  assign div_divisor  = cmd.div_time ? len_eff : rd_divisor;

  efa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // round half to even
  logic [LEN_BITS:0]     twice_rem;
  logic                  round_up;
  logic [LEVEL_BITS-1:0] rounded;

  assign twice_rem = {div_rem, 1'b0};
  assign round_up  = (twice_rem > {1'b0, rd_divisor}) ||
                     ((twice_rem == {1'b0, rd_divisor}) && div_quo[0]);
  assign rounded   = div_quo[LEVEL_BITS-1:0] + LEVEL_BITS'(round_up);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      present      <= 1'b0;
      bank         <= 1'b0;
      closed_flag  <= 1'b0;
      window_start <= '0;
      closed_stamp <= '0;
      sweep        <= '0;
      scan_pend    <= 1'b0;
      max_total    <= '0;
      max_pos      <= '0;
      max_neg      <= '0;
      max_abs      <= '0;
    end else begin
      scan_pend <= cmd.scan_step;
      if (cmd.capture) closed_flag <= 1'b0;
      if (cmd.set_start && !started) begin
        started      <= 1'b1;
        window_start <= item.timestamp;
      end
      if (cmd.sweep_reset) begin
        sweep <= '0;
      end else if (cmd.sweep_clear || cmd.scan_step) begin
        sweep <= sweep + 1'b1;
      end
      if (cmd.close_commit) begin
        max_total    <= acc_total;
        max_pos      <= acc_pos;
        max_neg      <= acc_neg;
        max_abs      <= acc_abs;
        closed_stamp <= window_start;
        // advance by whole window lengths
        window_start <= item.timestamp - TS_BITS'(div_rem);
        bank         <= ~bank;
        present      <= 1'b1;
        closed_flag  <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= item_in;
    scan_inside <= (16'(scan_col) < 16'(frame_width)) && (16'(scan_col) < 16'(MAX_COLS)) &&
                   (16'(scan_row) < 16'(frame_height)) && (16'(scan_row) < 16'(MAX_ROWS));
    if (cmd.sweep_reset) begin
      acc_total <= '0;
      acc_pos   <= '0;
      acc_neg   <= '0;
      acc_abs   <= '0;
    end else if (scan_pend && scan_inside) begin
      if (rd_total > acc_total) acc_total <= rd_total;
      if (rd_pos > acc_pos)     acc_pos   <= rd_pos;
      if (rd_neg > acc_neg)     acc_neg   <= rd_neg;
      if (rd_abs > acc_abs)     acc_abs   <= rd_abs;
    end
    if (cmd.pix_latch) begin
      pix_pos <= rd_pos;
      pix_neg <= rd_neg;
    end
    if (cmd.level_store) begin
      case (cmd.op)
        OP_TOTAL: lvl_count  <= rd_max_zero ? '0 : rounded;
        OP_POS:   lvl_red    <= rd_max_zero ? '0 : rounded;
        OP_NEG:   lvl_blue   <= rd_max_zero ? '0 : rounded;
        default:  lvl_signed <= rd_max_zero ? LEVEL_MID : rounded;
      endcase
    end
  end

  // result register
  logic read_ok;

  assign read_ok = item.func && present && item_inside;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.window_closed <= !item.func && closed_flag;
      out_item.frame_stamp   <= closed_stamp;
      out_item.read_valid    <= read_ok;
      out_item.count_gray    <= read_ok ? lvl_count : '0;
      out_item.signed_gray   <= read_ok ? lvl_signed : '0;
      out_item.binary_level  <= (read_ok && pix_total != '0) ? LEVEL_FULL : '0;
      out_item.red_level     <= read_ok ? lvl_red : '0;
      out_item.blue_level    <= read_ok ? lvl_blue : '0;
    end
  end

  always_comb begin
    status.is_read        = item.func;
    status.close_hit      = (item.timestamp >= window_start) &&
                            (ts_diff >= TS_BITS'(len_eff));
    status.sweep_last_pix = &sweep[PIX_BITS-1:0];
    status.sweep_last_all = &sweep;
    status.div_busy       = div_busy;
    status.out_free       = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ===== rtl/core/event_frame_accumulator.sv =====
// Event frame accumulator.
// Input channel in_valid/in_stall/in_item carries sensor events (func 0) and
// pixel reads of the last closed frame (func 1); output channel
// out_valid/out_stall/out_item returns one result beat for every input beat.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// One item is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register.
// An event does one read-modify-write of its pixel counters in the single
// counter RAM. An event that closes a window also scans the closing bank
// first, which clears the other bank in the same pass.
// A read runs four 64-step divisions on the shared iterative divider, one
// for each scaled level.
// After reset the counter RAM is cleared, one entry a cycle, over all
// 2^(PIX_BITS+1) entries (131072) with in_stall high; configuration writes
// are taken meanwhile.
// A result stalled by the receiver stays in the output register; the block
// then holds its next result until that beat is taken.
`default_nettype none

module event_frame_accumulator
  import efa_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire in_t                       in_item,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_t                           out_item
);

  cmd_t    cmd;
  status_t status;

  efa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  efa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .item_in   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled beat");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in work");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_time || cmd.div_read) |-> !status.div_busy)
    else $error("divider restarted while busy");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result beat without a load");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
  import efa_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 8000000;
  localparam bit [63:0] T0 = 64'hFFFF_0000_0000_0000;
  localparam int BANK_PIX = MAX_COLS * MAX_ROWS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  event_frame_accumulator dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the accumulator
  bit [15:0] pos_cnt [0:2*BANK_PIX-1];
  bit [15:0] neg_cnt [0:2*BANK_PIX-1];
  bit        bank;
  bit [63:0] win_start;
  bit        win_open;
  bit        have_frame;
  bit [63:0] frame_start;
  bit [16:0] max_tot, max_pos, max_neg, max_abs;
  bit [8:0]  cols_reg, rows_reg;
  bit [31:0] len_reg;

  out_t result_q[$];
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  int   n_bad = 0;
  longint unsigned cycles = 0;

  function automatic int eff_cols();
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  function automatic int eff_rows();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic bit [63:0] eff_len();
    return (len_reg == 0) ? 64'd1 : 64'(len_reg);
  endfunction

  function automatic bit [63:0] div_even(bit [63:0] num, bit [63:0] den);
    bit [63:0] q, r;
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q++;
    return q;
  endfunction

  function automatic void close_window();
    int base;
    bit [16:0] p, n, d;
    max_tot = 0; max_pos = 0; max_neg = 0; max_abs = 0;
    base = bank ? BANK_PIX : 0;
    for (int r = 0; r < eff_rows(); r++) begin
      for (int c = 0; c < eff_cols(); c++) begin
        p = pos_cnt[base + r * MAX_COLS + c];
        n = neg_cnt[base + r * MAX_COLS + c];
        d = (p > n) ? p - n : n - p;
        if (p + n > max_tot) max_tot = p + n;
        if (p > max_pos) max_pos = p;
        if (n > max_neg) max_neg = n;
        if (d > max_abs) max_abs = d;
      end
    end
    frame_start = win_start;
    have_frame = 1'b1;
    bank = ~bank;
    base = bank ? BANK_PIX : 0;
    for (int i = 0; i < BANK_PIX; i++) begin
      pos_cnt[base + i] = 0;
      neg_cnt[base + i] = 0;
    end
  endfunction

  function automatic out_t accumulate(in_t it);
    out_t o;
    bit hit;
    int a;
    bit [63:0] p, n, t, m, num;
    o = '0;
    hit = (int'(it.x) < eff_cols()) && (int'(it.y) < eff_rows());
    if (!it.func) begin
      if (!win_open) begin
        win_start = it.timestamp;
        win_open = 1'b1;
      end
      if (it.timestamp >= win_start && it.timestamp - win_start >= eff_len()) begin
        num = (it.timestamp - win_start) / eff_len();
        close_window();
        win_start += num * eff_len();
        o.window_closed = 1'b1;
      end
      if (hit) begin
        a = (bank ? BANK_PIX : 0) + int'(it.y) * MAX_COLS + int'(it.x);
        if (it.polarity) begin
          if (pos_cnt[a] != COUNT_MAX) pos_cnt[a]++;
        end else begin
          if (neg_cnt[a] != COUNT_MAX) neg_cnt[a]++;
        end
      end
    end else if (have_frame && hit) begin
      a = (bank ? 0 : BANK_PIX) + int'(it.y) * MAX_COLS + int'(it.x);
      p = pos_cnt[a];
      n = neg_cnt[a];
      t = p + n;
      o.read_valid = 1'b1;
      if (max_tot != 0) o.count_gray = 8'(div_even(t * 255, max_tot));
      if (max_abs != 0) begin
        m = max_abs;
        num = (p >= n) ? (p - n) * 127 + 127 * m : 127 * m - (n - p) * 127;
        o.signed_gray = 8'(div_even(num, m));
      end else begin
        o.signed_gray = LEVEL_MID;
      end
      o.binary_level = (t != 0) ? LEVEL_FULL : 8'd0;
      if (max_pos != 0) o.red_level = 8'(div_even(p * 255, max_pos));
      if (max_neg != 0) o.blue_level = 8'(div_even(n * 255, max_neg));
    end
    o.frame_stamp = frame_start;
    return o;
  endfunction

  function automatic in_t mk(bit f, bit [15:0] x, bit [15:0] y, bit pol, bit [63:0] ts);
    in_t it;
    it.func = f;
    it.x = x;
    it.y = y;
    it.polarity = pol;
    it.timestamp = ts;
    return it;
  endfunction

  // Random item: mostly reads and in-window events on the active frame
  function automatic in_t pick_item(bit closing);
    int r;
    bit [15:0] x, y;
    bit [63:0] ts;
    r = $urandom_range(99);
    if (eff_cols() == 0 || eff_rows() == 0 || $urandom_range(9) == 0) begin
      x = 16'($urandom);
      y = 16'($urandom);
    end else begin
      x = 16'($urandom_range(eff_cols() - 1));
      y = 16'($urandom_range(eff_rows() - 1));
    end
    ts = win_start + 64'($urandom) % eff_len();
    if (closing) begin
      ts = win_start + eff_len() * ((len_reg == '1) ? 1 : $urandom_range(1, 3))
           + 64'($urandom) % eff_len();
      return mk(1'b0, x, y, 1'($urandom), ts);
    end
    if (r < 35) return mk(1'b1, x, y, 1'($urandom), {$urandom, $urandom});
    if (r < 40) return mk(1'b0, x, y, 1'($urandom), {$urandom, $urandom});
    return mk(1'b0, x, y, 1'($urandom), ts);
  endfunction

  task automatic send(in_t it, bit typed = 1'b0, out_t want = '0);
    out_t o;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    o = accumulate(it);
    result_q.push_back(typed ? want : o);
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, bit [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:   cols_reg = val[8:0];
      CFG_FRAME_HEIGHT:  rows_reg = val[8:0];
      CFG_WINDOW_LENGTH: len_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_frame(bit [31:0] w, bit [31:0] h, bit [31:0] len);
    in_valid <= 1'b0;
    drain();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_WINDOW_LENGTH, len);
  endtask

  task automatic set_idle(int mode);
    case (mode % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 52; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 52; end
      default: begin gap_pct = 14; stall_pct = 14; end
    endcase
  endtask

  task automatic run_random(int count, int close_every);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) set_idle(i / 100);
      send(pick_item(close_every > 0 && i % close_every == close_every - 1));
    end
  endtask

  // Receiver: random stall, or a long hold when asked
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_t w;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat %p", out_item);
      end else begin
        w = result_q.pop_front();
        if (out_item.window_closed !== w.window_closed || out_item.frame_stamp !== w.frame_stamp
            || out_item.read_valid !== w.read_valid || out_item.count_gray !== w.count_gray
            || out_item.signed_gray !== w.signed_gray
            || out_item.binary_level !== w.binary_level
            || out_item.red_level !== w.red_level || out_item.blue_level !== w.blue_level) begin
          n_bad++;
          if (n_bad <= 10) $display("result mismatch: expected %p got %p", w, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("event_frame_accumulator test failed");
      $finish;
    end
  end

  typedef struct {
    in_t  it;
    bit   typed;
    out_t want;
  } step_t;

  initial begin
    step_t steps[$];
    out_t  bad_read;
    bank = 0; win_start = 0; win_open = 0; have_frame = 0; frame_start = 0;
    max_tot = 0; max_pos = 0; max_neg = 0; max_abs = 0;
    cols_reg = FRAME_DIM_RST; rows_reg = FRAME_DIM_RST; len_reg = WINDOW_LENGTH_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    bad_read = '0;
    bad_read.frame_stamp = T0;
    steps.push_back('{mk(1, 0, 0, 0, 0), 1, '0});
    // first event opens the window even when off-frame
    steps.push_back('{mk(0, 16'hFFFF, 0, 1, T0), 1, '0});
    steps.push_back('{mk(0, 0, 0, 1, T0 + 1), 0, '0});
    steps.push_back('{mk(0, 0, 0, 0, T0 + 2), 0, '0});
    steps.push_back('{mk(0, 255, 255, 0, T0 + 3), 0, '0});
    steps.push_back('{mk(0, 255, 255, 0, T0 + 4), 0, '0});
    steps.push_back('{mk(0, 3, 5, 1, T0 - 7), 0, '0});
    steps.push_back('{mk(0, 0, 16'hFFFF, 1, T0 + 5), 0, '0});
    steps.push_back('{mk(0, 1, 1, 1, T0 + 66000009), 0, '0});
    steps.push_back('{mk(1, 0, 0, 0, 0), 0, '0});
    steps.push_back('{mk(1, 255, 255, 1, 0), 0, '0});
    steps.push_back('{mk(1, 3, 5, 0, 0), 0, '0});
    steps.push_back('{mk(1, 1, 1, 0, 0), 0, '0});
    steps.push_back('{mk(1, 256, 0, 0, 0), 1, bad_read});
    steps.push_back('{mk(1, 16'hFFFF, 16'hFFFF, 1, '1), 1, bad_read});
    foreach (steps[i]) send(steps[i].it, steps[i].typed, steps[i].want);

    // oversized frame, zero window length acts as one tick
    set_frame(511, 300, 0);
    send(mk(0, 300, 2, 1, win_start));
    send(mk(0, 2, 2, 0, win_start + 5));
    run_random(40, 0);

    // zero dimensions: events ignored, reads invalid
    set_frame(0, 0, 1000);
    run_random(60, 0);

    set_frame(20, 12, 5000);
    hold_left = 400;
    run_random(1200, 300);

    set_frame(256, 256, 32'hFFFF_FFFF);
    run_random(400, 200);

    // pile events on one pixel, then close and read it back
    set_frame(1, 1, 32'hFFFF_FFFF);
    set_idle(0);
    for (int i = 0; i < 20; i++) send(mk(0, 0, 0, 1, win_start + 1));
    repeat (3) send(mk(0, 0, 0, 0, win_start + 2));
    send(pick_item(1'b1));
    send(mk(1, 0, 0, 0, 0));
    send(mk(1, 1, 0, 0, 0));

    in_valid <= 1'b0;
    drain();
    repeat (300) @(posedge clk);
    if (n_bad == 0 && result_q.size() == 0) begin
      $display("event_frame_accumulator test passed");
    end else begin
      $display("event_frame_accumulator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
